>>> hw/rtl/gabp_pkg.sv
package gabp_pkg;

    localparam int ROWS_DEF   = 8;
    localparam int COLS_DEF   = 16;

    // payload widths
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // internal coordinate and heuristic widths, sized for the largest grid
    localparam int COORD_W    = 5;
    localparam int D2_W       = 11;
    localparam int H_W        = 22;
    localparam int FRAC_W     = 16;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CUT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_QUERY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_Q_RD, S_Q_CHK, S_SINIT, S_SCLR, S_GOAL,
        S_NB_RD, S_NB_CHK, S_H_GO, S_H_WAIT, S_NB_WR, S_NB_NEXT,
        S_SCAN, S_POP, S_OK, S_FAIL, S_PCLR, S_W_RD, S_W_CHK,
        S_DONE, S_FIN_RD, S_FIN
    } t_state;

    typedef enum logic {MODE_UPD, MODE_PLACE} t_mode;

    typedef struct packed {
        logic           done;
        logic [H_W-1:0] root;
    } t_sqrt_rsp;

endpackage

>>> hw/rtl/gabp_req_if.sv
interface gabp_req_if;
    import gabp_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    modport source (output valid, op, row, col, input ready);
    modport sink   (input valid, op, row, col, output ready);
endinterface

>>> hw/rtl/gabp_rsp_if.sv
interface gabp_rsp_if;
    import gabp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                cell_blocked;
    logic                cell_on_path;
    logic [LEN_W-1:0]    path_length;

    modport source (output valid, status, cell_blocked, cell_on_path, path_length,
                    input ready);
    modport sink   (input valid, status, cell_blocked, cell_on_path, path_length,
                    output ready);
endinterface

>>> hw/rtl/gabp_isqrt.sv
module gabp_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gabp_pkg::D2_W-1:0]  i_d2,
    output gabp_pkg::t_sqrt_rsp        o_rsp
);
    import gabp_pkg::*;

    localparam int RAD_W = 2 * H_W;
    localparam int REM_W = H_W + 1;
    localparam int CNT_W = $clog2(H_W + 1);

    logic [RAD_W-1:0] r_rad, n_rad;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [H_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [H_W+2:0]   rem_sh;
    logic [H_W+2:0]   trial;

    // one result bit per cycle, two radicand bits shifted in each step
    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = RAD_W'(i_d2) << (2 * FRAC_W);
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(H_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (rem_sh >= trial) begin
                n_rem  = REM_W'(rem_sh - trial);
                n_root = {r_root[H_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(rem_sh);
                n_root = {r_root[H_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

>>> hw/rtl/grid_astar_blocker_placement_top.sv
// Blocker placement on a grid with a kept shortest path between two endpoints.
// Request channel (i_req): op, row, col. Place (op 0) blocks a cell and reruns
// an A* search from the goal to the start, unblocking the cell again if the path is cut;
// query (op 1) reads one cell. Response channel (o_rsp): one beat per request with status,
// cell_blocked, cell_on_path and path_length. Config port: i_cfg_we, i_cfg_idx, i_cfg_data
// writes start/goal row/col and starts a fresh path search.
// A query or a refused place latches the request, reads the cell's blocked and path bits
// and registers the response beat. An accepted place clears the node memory, runs the
// search, then clears and rewalks the path if one was found; the bit-serial square root
// for each opened cell and the one-entry-per-cycle open list scan at each expansion
// dominate its run time.
// One request is in work at a time; i_req.ready is low while the block works
// and while a response beat waits on a stalled receiver.
// Reset: a clearing pass over every cell of the grid, then the initial search;
// the block is ready once that search and path walk finish.
module grid_astar_blocker_placement_top #(
    parameter int ROWS = gabp_pkg::ROWS_DEF,
    parameter int COLS = gabp_pkg::COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gabp_req_if.sink                          i_req,
    gabp_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [gabp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gabp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gabp_pkg::*;

    localparam int NCELL  = ROWS * COLS;
    localparam int CW     = $clog2(NCELL);
    localparam int CNT_W  = $clog2(NCELL + 1);
    localparam int COST_W = CNT_W;
    localparam int EST_W  = ((COST_W > 6) ? COST_W : 6) + FRAC_W + 1;

    typedef struct packed {
        logic              is_open;
        logic              is_closed;
        logic [COST_W-1:0] cost;
        logic [EST_W-1:0]  est;
        logic [1:0]        par;
    } t_node;

    typedef struct packed {
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
    } t_rc;

    typedef struct packed {
        logic off;
        t_rc  p;
    } t_nbr;

    function automatic logic [CW-1:0] cell_addr(input t_rc p);
        return CW'(int'(p.r) * COLS + int'(p.c));
    endfunction

    function automatic t_nbr step_cell(input t_rc p, input logic [1:0] d);
        t_nbr q;
        q.off = 1'b0;
        q.p   = p;
        case (d)
            DIR_UP: begin
                if (p.r == '0) q.off = 1'b1;
                else q.p.r = p.r - 1'b1;
            end
            DIR_DOWN: begin
                if (p.r == COORD_W'(ROWS - 1)) q.off = 1'b1;
                else q.p.r = p.r + 1'b1;
            end
            DIR_LEFT: begin
                if (p.c == '0) q.off = 1'b1;
                else q.p.c = p.c - 1'b1;
            end
            default: begin
                if (p.c == COORD_W'(COLS - 1)) q.off = 1'b1;
                else q.p.c = p.c + 1'b1;
            end
        endcase
        return q;
    endfunction

    // state and control
    t_state            r_state, n_state;
    t_mode             r_mode;
    logic              r_redo;
    logic [ROW_W-1:0]  r_start_row, r_goal_row;
    logic [COL_W-1:0]  r_start_col, r_goal_col;

    // latched request
    logic              r_op;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_cell_ok;
    logic [CW-1:0]     r_cell_addr;

    // search datapath
    logic [CW-1:0]     r_i;
    logic [CNT_W-1:0]  r_k, r_olen, r_live, r_count;
    t_rc               r_cur, r_nb, r_s2_rc, r_best_rc;
    logic [COST_W-1:0] r_cur_cost, r_ng;
    logic [1:0]        r_d;
    logic              r_nb_new;
    logic [D2_W-1:0]   r_d2;
    logic              r_s1_v, r_s2_v, r_best_v;
    t_node             r_best;
    logic              r_ok;
    logic [STATUS_W-1:0] r_status;

    // response register
    logic              r_out_v;
    logic [STATUS_W-1:0] r_out_status;
    logic              r_out_blk, r_out_path;
    logic [LEN_W-1:0]  r_out_len;

    // memories
    t_node             node_mem [NCELL];
    logic              blk_mem  [NCELL];
    logic              path_mem [NCELL];
    t_rc               olist    [NCELL];
    t_node             r_node_q;
    logic              r_blk_q, r_path_q;
    t_rc               r_ol_q;

    logic              node_we, blk_we, path_we, ol_we;
    logic [CW-1:0]     node_waddr, node_raddr, blk_waddr, blk_raddr;
    logic [CW-1:0]     path_waddr, path_raddr, ol_waddr, ol_raddr;
    t_node             node_wdata;
    logic              blk_wdata, path_wdata;
    t_rc               ol_wdata;

    logic              sq_start;
    t_sqrt_rsp         sq_rsp;

    // derived values
    t_rc               start_rc, goal_rc, req_rc;
    logic              ends_ok, req_ok, req_ready, req_acc;
    logic              is_end, place_go;
    t_nbr              nb_cur, walk_nb;
    logic [COST_W-1:0] ng;
    logic              nb_take, scan_done, scan_hit, walk_go, last_i;
    logic [COORD_W-1:0] dr, dc;
    logic [D2_W-1:0]   drx, dcx, d2_nb;
    logic [LEN_W-1:0]  len_sat;
    t_node             nb_word, pop_word, goal_word;

    assign start_rc = '{r: COORD_W'(r_start_row), c: COORD_W'(r_start_col)};
    assign goal_rc  = '{r: COORD_W'(r_goal_row),  c: COORD_W'(r_goal_col)};
    assign req_rc   = '{r: COORD_W'(i_req.row),   c: COORD_W'(i_req.col)};
    assign ends_ok  = (int'(r_start_row) < ROWS) && (int'(r_start_col) < COLS) &&
                      (int'(r_goal_row) < ROWS) && (int'(r_goal_col) < COLS);
    assign req_ok   = (int'(i_req.row) < ROWS) && (int'(i_req.col) < COLS);
    assign req_acc  = i_req.valid && req_ready;
    assign is_end   = ((r_row == r_start_row) && (r_col == r_start_col)) ||
                      ((r_row == r_goal_row) && (r_col == r_goal_col));
    assign place_go = (r_op == OP_PLACE) && r_cell_ok && !r_blk_q && !is_end;
    assign nb_cur   = step_cell(r_cur, r_d);
    assign walk_nb  = step_cell(r_cur, r_node_q.par);
    assign ng       = r_cur_cost + 1'b1;
    assign nb_take  = !r_blk_q && !r_node_q.is_closed &&
                      (!r_node_q.is_open || (ng < r_node_q.cost));
    assign scan_done = (r_k == r_olen) && !r_s1_v && !r_s2_v;
    assign scan_hit  = r_s2_v && r_node_q.is_open &&
                       (!r_best_v || (r_node_q.est < r_best.est));
    assign walk_go  = !walk_nb.off && (walk_nb.p != goal_rc) &&
                      (r_k != CNT_W'(NCELL));
    assign last_i   = (r_i == CW'(NCELL - 1));
    assign len_sat  = (int'(r_count) > 127) ? LEN_W'(127) : LEN_W'(r_count);

    // squared distance of the neighbor under test to the start cell
    always_comb begin
        dr    = (r_nb.r > start_rc.r) ? r_nb.r - start_rc.r : start_rc.r - r_nb.r;
        dc    = (r_nb.c > start_rc.c) ? r_nb.c - start_rc.c : start_rc.c - r_nb.c;
        drx   = D2_W'(dr);
        dcx   = D2_W'(dc);
        d2_nb = drx * drx + dcx * dcx;
    end

    always_comb begin
        nb_word.is_open   = 1'b1;
        nb_word.is_closed = 1'b0;
        nb_word.cost      = r_ng;
        nb_word.est       = (EST_W'(r_ng) << FRAC_W) + EST_W'(sq_rsp.root);
        nb_word.par       = r_d ^ 2'b01;
        pop_word           = r_best;
        pop_word.is_open   = 1'b0;
        pop_word.is_closed = 1'b1;
        goal_word           = '0;
        goal_word.is_closed = 1'b1;
    end

    gabp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_d2    (r_d2),
        .o_rsp   (sq_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:     if (last_i) n_state = S_SINIT;
            S_IDLE: begin
                if (i_cfg_we || r_redo) n_state = S_SINIT;
                else if (req_acc) n_state = S_Q_RD;
            end
            S_Q_RD:    n_state = S_Q_CHK;
            S_Q_CHK:   n_state = place_go ? S_SINIT : S_IDLE;
            S_SINIT:   n_state = ends_ok ? S_SCLR : S_FAIL;
            S_SCLR:    if (last_i) n_state = S_GOAL;
            S_GOAL:    n_state = S_NB_RD;
            S_NB_RD:   n_state = nb_cur.off ? S_NB_NEXT : S_NB_CHK;
            S_NB_CHK:  n_state = nb_take ? S_H_GO : S_NB_NEXT;
            S_H_GO:    n_state = S_H_WAIT;
            S_H_WAIT:  if (sq_rsp.done) n_state = S_NB_WR;
            S_NB_WR:   n_state = S_NB_NEXT;
            S_NB_NEXT: begin
                if (r_d != DIR_RIGHT) n_state = S_NB_RD;
                else if (r_live == '0) n_state = S_FAIL;
                else n_state = S_SCAN;
            end
            S_SCAN:    if (scan_done) n_state = S_POP;
            S_POP:     n_state = (r_best_rc == start_rc) ? S_OK : S_NB_RD;
            S_OK:      n_state = S_PCLR;
            S_FAIL:    n_state = (r_mode == MODE_PLACE) ? S_FIN_RD : S_PCLR;
            S_PCLR:    if (last_i) n_state = r_ok ? S_W_RD : S_DONE;
            S_W_RD:    n_state = S_W_CHK;
            S_W_CHK:   n_state = walk_go ? S_W_RD : S_DONE;
            S_DONE:    n_state = (r_mode == MODE_PLACE) ? S_FIN_RD : S_IDLE;
            S_FIN_RD:  n_state = S_FIN;
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb begin
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_raddr = '0;
        blk_we     = 1'b0;
        blk_waddr  = '0;
        blk_wdata  = 1'b0;
        blk_raddr  = '0;
        path_we    = 1'b0;
        path_waddr = '0;
        path_wdata = 1'b0;
        path_raddr = '0;
        ol_we      = 1'b0;
        ol_waddr   = '0;
        ol_wdata   = '0;
        ol_raddr   = '0;
        sq_start   = 1'b0;
        req_ready  = 1'b0;
        case (r_state)
            S_CLR: begin
                blk_we     = 1'b1;
                blk_waddr  = r_i;
                path_we    = 1'b1;
                path_waddr = r_i;
            end
            S_IDLE: req_ready = !r_out_v && !r_redo && !i_cfg_we;
            S_Q_RD, S_FIN_RD: begin
                blk_raddr  = r_cell_addr;
                path_raddr = r_cell_addr;
            end
            S_Q_CHK: begin
                if (place_go) begin
                    blk_we    = 1'b1;
                    blk_waddr = r_cell_addr;
                    blk_wdata = 1'b1;
                end
            end
            S_SCLR: begin
                node_we    = 1'b1;
                node_waddr = r_i;
            end
            S_GOAL: begin
                node_we    = 1'b1;
                node_waddr = cell_addr(goal_rc);
                node_wdata = goal_word;
            end
            S_NB_RD: begin
                node_raddr = cell_addr(nb_cur.p);
                blk_raddr  = cell_addr(nb_cur.p);
            end
            S_H_GO: sq_start = 1'b1;
            S_NB_WR: begin
                node_we    = 1'b1;
                node_waddr = cell_addr(r_nb);
                node_wdata = nb_word;
                ol_we      = r_nb_new;
                ol_waddr   = r_olen[CW-1:0];
                ol_wdata   = r_nb;
            end
            S_SCAN: begin
                ol_raddr   = r_k[CW-1:0];
                node_raddr = cell_addr(r_ol_q);
            end
            S_POP: begin
                node_we    = 1'b1;
                node_waddr = cell_addr(r_best_rc);
                node_wdata = pop_word;
            end
            S_FAIL: begin
                if (r_mode == MODE_PLACE) begin
                    blk_we    = 1'b1;
                    blk_waddr = r_cell_addr;
                end
            end
            S_PCLR: begin
                path_we    = 1'b1;
                path_waddr = r_i;
            end
            S_W_RD: node_raddr = cell_addr(r_cur);
            S_W_CHK: begin
                if (walk_go) begin
                    path_we    = 1'b1;
                    path_waddr = cell_addr(walk_nb.p);
                    path_wdata = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (node_we) node_mem[node_waddr] <= node_wdata;
        r_node_q <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
        r_blk_q <= blk_mem[blk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) path_mem[path_waddr] <= path_wdata;
        r_path_q <= path_mem[path_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ol_we) olist[ol_waddr] <= ol_wdata;
        r_ol_q <= olist[ol_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_mode      <= MODE_UPD;
            r_redo      <= 1'b0;
            r_i         <= '0;
            r_count     <= '0;
            r_out_v     <= 1'b0;
            r_start_row <= ROW_W'(3);
            r_start_col <= COL_W'(0);
            r_goal_row  <= ROW_W'(3);
            r_goal_col  <= COL_W'(15);
        end else begin
            r_state <= n_state;

            if (r_state == S_IDLE && n_state == S_SINIT) begin
                r_redo <= 1'b0;
                r_mode <= MODE_UPD;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_ROW: r_start_row <= i_cfg_data[ROW_W-1:0];
                    CFG_START_COL: r_start_col <= i_cfg_data[COL_W-1:0];
                    CFG_GOAL_ROW:  r_goal_row  <= i_cfg_data[ROW_W-1:0];
                    CFG_GOAL_COL:  r_goal_col  <= i_cfg_data[COL_W-1:0];
                    default: ;
                endcase
                // a write while busy reruns the search once it settles
                if (r_state != S_IDLE) r_redo <= 1'b1;
            end

            if (o_rsp.valid && o_rsp.ready) r_out_v <= 1'b0;

            case (r_state)
                S_CLR, S_SCLR: r_i <= last_i ? '0 : r_i + 1'b1;
                S_IDLE: begin
                    if (req_acc) begin
                        r_op        <= i_req.op;
                        r_row       <= i_req.row;
                        r_col       <= i_req.col;
                        r_cell_ok   <= req_ok;
                        r_cell_addr <= req_ok ? cell_addr(req_rc) : '0;
                    end
                end
                S_Q_CHK: begin
                    if (place_go) begin
                        r_mode <= MODE_PLACE;
                    end else begin
                        r_out_v      <= 1'b1;
                        r_out_status <= (r_op == OP_QUERY) ? ST_QUERY : ST_REFUSED;
                        r_out_blk    <= r_cell_ok & r_blk_q;
                        r_out_path   <= r_cell_ok & r_path_q;
                        r_out_len    <= len_sat;
                    end
                end
                S_SINIT: r_i <= '0;
                S_GOAL: begin
                    r_cur      <= goal_rc;
                    r_cur_cost <= '0;
                    r_olen     <= '0;
                    r_live     <= '0;
                    r_d        <= DIR_UP;
                end
                S_NB_RD:  r_nb <= nb_cur.p;
                S_NB_CHK: begin
                    r_nb_new <= !r_node_q.is_open;
                    r_ng     <= ng;
                    r_d2     <= d2_nb;
                end
                S_NB_WR: begin
                    if (r_nb_new) begin
                        r_olen <= r_olen + 1'b1;
                        r_live <= r_live + 1'b1;
                    end
                end
                S_NB_NEXT: begin
                    if (r_d != DIR_RIGHT) begin
                        r_d <= r_d + 1'b1;
                    end else begin
                        r_k      <= '0;
                        r_s1_v   <= 1'b0;
                        r_s2_v   <= 1'b0;
                        r_best_v <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // list read, then node read, then compare; strict less keeps the first
                    r_s1_v  <= (r_k != r_olen);
                    if (r_k != r_olen) r_k <= r_k + 1'b1;
                    r_s2_v  <= r_s1_v;
                    r_s2_rc <= r_ol_q;
                    if (scan_hit) begin
                        r_best_v  <= 1'b1;
                        r_best_rc <= r_s2_rc;
                        r_best    <= r_node_q;
                    end
                end
                S_POP: begin
                    r_cur      <= r_best_rc;
                    r_cur_cost <= r_best.cost;
                    r_live     <= r_live - 1'b1;
                    r_d        <= DIR_UP;
                end
                S_OK: begin
                    r_ok     <= 1'b1;
                    r_status <= ST_PLACED;
                end
                S_FAIL: begin
                    r_ok     <= 1'b0;
                    r_status <= ST_CUT;
                end
                S_PCLR: begin
                    r_i     <= last_i ? '0 : r_i + 1'b1;
                    r_count <= '0;
                    if (last_i) begin
                        r_cur <= start_rc;
                        r_k   <= '0;
                    end
                end
                S_W_CHK: begin
                    if (walk_go) begin
                        r_cur   <= walk_nb.p;
                        r_count <= r_count + 1'b1;
                        r_k     <= r_k + 1'b1;
                    end
                end
                S_FIN: begin
                    r_out_v      <= 1'b1;
                    r_out_status <= r_status;
                    r_out_blk    <= r_cell_ok & r_blk_q;
                    r_out_path   <= r_cell_ok & r_path_q;
                    r_out_len    <= len_sat;
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.cell_blocked = r_out_blk;
    assign o_rsp.cell_on_path = r_out_path;
    assign o_rsp.path_length  = r_out_len;

endmodule
